// File: sv/ter_pkg.sv
// Shared constants, codes and control structures of the triangle edge rasterizer.
`default_nettype none
package ter_pkg;

	localparam int COORD_BITS = 12;
	localparam int DW = COORD_BITS + 1;
	localparam int WW = 2 * COORD_BITS + 3;
	localparam int NW = (WW - 1) + 8 + 2;
	localparam int AW = 5;
	localparam int DATA_W = 32;

	localparam logic KIND_START = 1'b0;
	localparam logic KIND_STEP = 1'b1;

	localparam logic [2:0] REG_V0_COLOR = 3'd0;
	localparam logic [2:0] REG_V1_COLOR = 3'd1;
	localparam logic [2:0] REG_V2_COLOR = 3'd2;
	localparam logic [2:0] REG_SCR_WIDTH = 3'd3;
	localparam logic [2:0] REG_SCR_HEIGHT = 3'd4;

	typedef struct packed {
		logic start;
		logic step;
		logic setup;
		logic mul;
		logic sat;
		logic div;
		logic [2:0] cnt;
		logic load_out;
	} ter_cmd_t;

	typedef struct packed {
		logic empty;
		logic active;
		logic frag_wr;
	} ter_stat_t;

endpackage
`default_nettype wire

// File: sv/ter_if.sv
// Valid/ready channel interfaces for start/step items and for fragments.
`default_nettype none
interface ter_in_if;
	import ter_pkg::*;
	logic valid;
	logic ready;
	logic kind;
	logic signed [COORD_BITS-1:0] first_x;
	logic signed [COORD_BITS-1:0] first_y;
	logic signed [COORD_BITS-1:0] second_x;
	logic signed [COORD_BITS-1:0] second_y;
	logic signed [COORD_BITS-1:0] third_x;
	logic signed [COORD_BITS-1:0] third_y;
	modport source(output valid, kind, first_x, first_y, second_x, second_y, third_x,
		third_y, input ready);
	modport sink(input valid, kind, first_x, first_y, second_x, second_y, third_x,
		third_y, output ready);
endinterface

interface ter_out_if;
	import ter_pkg::*;
	logic valid;
	logic ready;
	logic signed [COORD_BITS-1:0] pixel_x;
	logic signed [COORD_BITS-1:0] pixel_y;
	logic write_pixel;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic last;
	modport source(output valid, pixel_x, pixel_y, write_pixel, red, green, blue, last,
		input ready);
	modport sink(input valid, pixel_x, pixel_y, write_pixel, red, green, blue, last,
		output ready);
endinterface
`default_nettype wire

// File: sv/triangle_edge_rasterizer.sv
// Top level of the edge-function triangle rasterizer with the top-left fill rule.
// Usage: a start transfer on the cmd channel (kind 0) loads three vertices and latches
// the box and edge deltas. Setup then runs the shared cross-product unit (doubled area,
// then one edge weight per cycle). A degenerate box instead yields a single fragment
// with write_pixel clear and last set. Each step transfer (kind 1) returns one fragment
// on the frag channel in raster order. A fragment that is not written goes from the
// check state to the output state; a written one first runs the product states, one
// saturation check and the restoring divider for its eight quotient bits.
// Steps while no scan runs return nothing. A start during a scan replaces it.
// The fragment sits in an output register; the block accepts the next transfer while it
// waits, and only holds a new result back until the receiver takes the old one.
// Reset clears the sequencer, the scan active flag and the output valid, and loads the
// register defaults. Register writes through the APB port are expected while idle.
`default_nettype none
module triangle_edge_rasterizer (
	input wire logic clk,
	input wire logic arst_n,
	ter_in_if.sink cmd,
	ter_out_if.source frag,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [ter_pkg::AW-1:0] paddr,
	input wire logic [ter_pkg::DATA_W-1:0] pwdata,
	output logic [ter_pkg::DATA_W-1:0] prdata,
	output logic pready
);
	import ter_pkg::*;

	ter_cmd_t dp_cmd;
	ter_stat_t dp_stat;
	logic [23:0] color0, color1, color2;
	logic [10:0] scr_width, scr_height;

	// Register bank on the APB port.
	ter_cfg u_cfg (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready),
		.color0(color0), .color1(color1), .color2(color2),
		.scr_width(scr_width), .scr_height(scr_height)
	);

	// The controller owns both handshakes; the datapath only follows its commands.
	ter_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(cmd.valid), .in_kind(cmd.kind), .in_ready(cmd.ready),
		.out_ready(frag.ready), .out_valid(frag.valid),
		.stat(dp_stat), .cmd(dp_cmd)
	);

	ter_dp u_dp (
		.clk(clk), .arst_n(arst_n),
		.cmd(dp_cmd), .stat(dp_stat),
		.in_x0(cmd.first_x), .in_y0(cmd.first_y),
		.in_x1(cmd.second_x), .in_y1(cmd.second_y),
		.in_x2(cmd.third_x), .in_y2(cmd.third_y),
		.color0(color0), .color1(color1), .color2(color2),
		.scr_width(scr_width), .scr_height(scr_height),
		.pixel_x(frag.pixel_x), .pixel_y(frag.pixel_y), .write_pixel(frag.write_pixel),
		.red(frag.red), .green(frag.green), .blue(frag.blue), .last(frag.last)
	);
endmodule
`default_nettype wire

// File: sv/ter_cfg.sv
// APB register bank: vertex colors and screen size.
`default_nettype none
module ter_cfg (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [ter_pkg::AW-1:0] paddr,
	input wire logic [ter_pkg::DATA_W-1:0] pwdata,
	output logic [ter_pkg::DATA_W-1:0] prdata,
	output logic pready,
	output logic [23:0] color0,
	output logic [23:0] color1,
	output logic [23:0] color2,
	output logic [10:0] scr_width,
	output logic [10:0] scr_height
);
	import ter_pkg::*;

	logic [2:0] idx;
	logic wr_en;

	assign idx = paddr[AW-1:2];
	assign wr_en = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color0 <= 24'hFF0000;
			color1 <= 24'h00FF00;
			color2 <= 24'h0000FF;
			scr_width <= 11'd800;
			scr_height <= 11'd600;
		end else if (wr_en) begin
			case (idx)
				REG_V0_COLOR: color0 <= pwdata[23:0];
				REG_V1_COLOR: color1 <= pwdata[23:0];
				REG_V2_COLOR: color2 <= pwdata[23:0];
				REG_SCR_WIDTH: scr_width <= pwdata[10:0];
				REG_SCR_HEIGHT: scr_height <= pwdata[10:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_V0_COLOR: prdata = {8'd0, color0};
			REG_V1_COLOR: prdata = {8'd0, color1};
			REG_V2_COLOR: prdata = {8'd0, color2};
			REG_SCR_WIDTH: prdata = {21'd0, scr_width};
			REG_SCR_HEIGHT: prdata = {21'd0, scr_height};
			default: prdata = '0;
		endcase
	end
endmodule
`default_nettype wire

// File: sv/ter_ctrl.sv
// Sequencer: handshakes, setup steps, color multiply and divide steps, output register valid.
`default_nettype none
module ter_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_kind,
	output logic in_ready,
	input wire logic out_ready,
	output logic out_valid,
	input wire ter_pkg::ter_stat_t stat,
	output ter_pkg::ter_cmd_t cmd
);
	import ter_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SETUP = 3'd1;
	localparam logic [2:0] ST_CHK = 3'd2;
	localparam logic [2:0] ST_MUL = 3'd3;
	localparam logic [2:0] ST_SAT = 3'd4;
	localparam logic [2:0] ST_DIV = 3'd5;
	localparam logic [2:0] ST_OUT = 3'd6;

	logic [2:0] state_q, state_d;
	logic [2:0] cnt_q, cnt_d;
	logic out_v_q;

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_v_q;

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		cmd = '0;
		cmd.cnt = cnt_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_kind == KIND_START) begin
						cmd.start = 1'b1;
						cnt_d = 3'd0;
						state_d = stat.empty ? ST_OUT : ST_SETUP;
					end else begin
						cmd.step = 1'b1;
						state_d = stat.active ? ST_CHK : ST_IDLE;
					end
				end
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				cnt_d = cnt_q + 3'd1;
				if (cnt_q == 3'd3) state_d = ST_IDLE;
			end
			ST_CHK: begin
				cnt_d = 3'd0;
				state_d = stat.frag_wr ? ST_MUL : ST_OUT;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				cnt_d = cnt_q + 3'd1;
				if (cnt_q == 3'd2) state_d = ST_SAT;
			end
			ST_SAT: begin
				cmd.sat = 1'b1;
				cnt_d = 3'd7;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div = 1'b1;
				cnt_d = cnt_q - 3'd1;
				if (cnt_q == 3'd0) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!out_v_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			if (cmd.load_out) out_v_q <= 1'b1;
			else if (out_ready) out_v_q <= 1'b0;
		end
	end
endmodule
`default_nettype wire

// File: sv/ter_dp.sv
// Datapath: triangle setup, edge weight stepping, color products and restoring divide.
`default_nettype none
module ter_dp (
	input wire logic clk,
	input wire logic arst_n,
	input wire ter_pkg::ter_cmd_t cmd,
	output ter_pkg::ter_stat_t stat,
	input wire logic signed [ter_pkg::COORD_BITS-1:0] in_x0,
	input wire logic signed [ter_pkg::COORD_BITS-1:0] in_y0,
	input wire logic signed [ter_pkg::COORD_BITS-1:0] in_x1,
	input wire logic signed [ter_pkg::COORD_BITS-1:0] in_y1,
	input wire logic signed [ter_pkg::COORD_BITS-1:0] in_x2,
	input wire logic signed [ter_pkg::COORD_BITS-1:0] in_y2,
	input wire logic [23:0] color0,
	input wire logic [23:0] color1,
	input wire logic [23:0] color2,
	input wire logic [10:0] scr_width,
	input wire logic [10:0] scr_height,
	output logic signed [ter_pkg::COORD_BITS-1:0] pixel_x,
	output logic signed [ter_pkg::COORD_BITS-1:0] pixel_y,
	output logic write_pixel,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue,
	output logic last
);
	import ter_pkg::*;

	localparam int CW = COORD_BITS;

	logic signed [CW-1:0] vx_q [3];
	logic signed [CW-1:0] vy_q [3];
	logic signed [CW-1:0] xmin_q, ymin_q;
	logic signed [CW-1:0] box_left_q, box_right_q, box_bottom_q;
	logic signed [CW-1:0] col_q, row_q;
	logic signed [DW-1:0] col_d_q [3];
	logic signed [DW-1:0] row_d_q [3];
	logic signed [WW-1:0] area_q;
	logic signed [WW-1:0] rsw_q [3];
	logic signed [WW-1:0] ew_q [3];
	logic active_q;

	logic signed [CW-1:0] frag_x_q, frag_y_q;
	logic frag_wr_q, frag_fin_q;
	logic signed [WW-1:0] fw_q [3];

	logic [NW-1:0] rem_q [3];
	logic [7:0] quo_q [3];
	logic sat_q [3];

	logic signed [CW-1:0] xmin, xmax, ymin, ymax, m01;
	logic empty;

	// Bounding box of the incoming vertices.
	always_comb begin
		m01 = (in_x0 < in_x1) ? in_x0 : in_x1;
		xmin = (m01 < in_x2) ? m01 : in_x2;
		m01 = (in_x0 > in_x1) ? in_x0 : in_x1;
		xmax = (m01 > in_x2) ? m01 : in_x2;
		m01 = (in_y0 < in_y1) ? in_y0 : in_y1;
		ymin = (m01 < in_y2) ? m01 : in_y2;
		m01 = (in_y0 > in_y1) ? in_y0 : in_y1;
		ymax = (m01 > in_y2) ? m01 : in_y2;
	end
	assign empty = (xmin == xmax) || (ymin == ymax);

	// Setup: doubled area first, then each edge function at the box corner.
	logic signed [CW-1:0] ax, ay, bx, by, cx, cy;
	logic signed [DW-1:0] d1, d2, d3, d4;
	logic signed [2*DW-1:0] p1, p2;
	logic signed [WW-1:0] crs;
	logic [1:0] ei;
	logic bias;

	assign ei = 2'(cmd.cnt - 3'd1);

	always_comb begin
		case (cmd.cnt)
			3'd0: begin
				ax = vx_q[0]; ay = vy_q[0]; bx = vx_q[1]; by = vy_q[1];
				cx = vx_q[2]; cy = vy_q[2];
			end
			3'd1: begin
				ax = vx_q[1]; ay = vy_q[1]; bx = vx_q[2]; by = vy_q[2];
				cx = xmin_q; cy = ymin_q;
			end
			3'd2: begin
				ax = vx_q[2]; ay = vy_q[2]; bx = vx_q[0]; by = vy_q[0];
				cx = xmin_q; cy = ymin_q;
			end
			default: begin
				ax = vx_q[0]; ay = vy_q[0]; bx = vx_q[1]; by = vy_q[1];
				cx = xmin_q; cy = ymin_q;
			end
		endcase
		d1 = DW'(bx) - DW'(ax);
		d2 = DW'(cy) - DW'(ay);
		d3 = DW'(by) - DW'(ay);
		d4 = DW'(cx) - DW'(ax);
		p1 = d1 * d2;
		p2 = d3 * d4;
		crs = WW'(p1) - WW'(p2);
		// An edge that is neither a top edge nor a left edge loses one.
		bias = !((col_d_q[ei] > 0) || ((col_d_q[ei] == 0) && (row_d_q[ei] > 0)));
	end

	// Fragment tests at the current scan position.
	logic covered, on_scr, fin;
	assign covered = !ew_q[0][WW-1] && !ew_q[1][WW-1] && !ew_q[2][WW-1]
		&& !area_q[WW-1] && (area_q != '0);
	assign on_scr = !col_q[CW-1] && (col_q[10:0] < scr_width) && (CW'(0) == (col_q >>> 11))
		&& !row_q[CW-1] && (row_q[10:0] < scr_height) && (CW'(0) == (row_q >>> 11));
	assign fin = (col_q == box_right_q) && (row_q == box_bottom_q);

	// Color products for one channel per cycle.
	logic [7:0] c0, c1, c2;
	logic [NW-1:0] num;
	logic [WW-2:0] area_mag;
	logic [NW-1:0] dsh, dsat;

	always_comb begin
		case (cmd.cnt)
			3'd0: begin c0 = color0[23:16]; c1 = color1[23:16]; c2 = color2[23:16]; end
			3'd1: begin c0 = color0[15:8]; c1 = color1[15:8]; c2 = color2[15:8]; end
			default: begin c0 = color0[7:0]; c1 = color1[7:0]; c2 = color2[7:0]; end
		endcase
		num = NW'(fw_q[0][WW-2:0]) * NW'(c0) + NW'(fw_q[1][WW-2:0]) * NW'(c1)
			+ NW'(fw_q[2][WW-2:0]) * NW'(c2);
	end

	assign area_mag = area_q[WW-2:0];
	assign dsh = NW'(area_mag) << cmd.cnt;
	assign dsat = NW'(area_mag) << 8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (cmd.start) begin
			active_q <= !empty;
		end else if (cmd.step && active_q && fin) begin
			active_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			vx_q[0] <= in_x0; vy_q[0] <= in_y0;
			vx_q[1] <= in_x1; vy_q[1] <= in_y1;
			vx_q[2] <= in_x2; vy_q[2] <= in_y2;
			xmin_q <= xmin;
			ymin_q <= ymin;
			box_left_q <= xmin;
			box_right_q <= xmax - CW'(1);
			box_bottom_q <= ymax - CW'(1);
			col_q <= xmin;
			row_q <= ymin;
			col_d_q[0] <= DW'(in_y1) - DW'(in_y2);
			col_d_q[1] <= DW'(in_y2) - DW'(in_y0);
			col_d_q[2] <= DW'(in_y0) - DW'(in_y1);
			row_d_q[0] <= DW'(in_x2) - DW'(in_x1);
			row_d_q[1] <= DW'(in_x0) - DW'(in_x2);
			row_d_q[2] <= DW'(in_x1) - DW'(in_x0);
			frag_x_q <= xmin;
			frag_y_q <= ymin;
			frag_wr_q <= 1'b0;
			frag_fin_q <= 1'b1;
		end
		if (cmd.setup) begin
			if (cmd.cnt == 3'd0) begin
				area_q <= crs;
			end else begin
				rsw_q[ei] <= crs - WW'(bias);
				ew_q[ei] <= crs - WW'(bias);
			end
		end
		if (cmd.step && active_q) begin
			frag_x_q <= col_q;
			frag_y_q <= row_q;
			frag_wr_q <= covered && on_scr;
			frag_fin_q <= fin;
			for (int i = 0; i < 3; i++) fw_q[i] <= ew_q[i];
			if (!fin) begin
				if (col_q == box_right_q) begin
					col_q <= box_left_q;
					row_q <= row_q + CW'(1);
					for (int i = 0; i < 3; i++) begin
						rsw_q[i] <= rsw_q[i] + WW'(row_d_q[i]);
						ew_q[i] <= rsw_q[i] + WW'(row_d_q[i]);
					end
				end else begin
					col_q <= col_q + CW'(1);
					for (int i = 0; i < 3; i++) ew_q[i] <= ew_q[i] + WW'(col_d_q[i]);
				end
			end
		end
		if (cmd.mul) begin
			rem_q[cmd.cnt[1:0]] <= num;
		end
		if (cmd.sat) begin
			for (int i = 0; i < 3; i++) begin
				sat_q[i] <= rem_q[i] >= dsat;
				quo_q[i] <= '0;
			end
		end
		if (cmd.div) begin
			for (int i = 0; i < 3; i++) begin
				if (rem_q[i] >= dsh) begin
					rem_q[i] <= rem_q[i] - dsh;
					quo_q[i][cmd.cnt] <= 1'b1;
				end
			end
		end
		if (cmd.load_out) begin
			pixel_x <= frag_x_q;
			pixel_y <= frag_y_q;
			write_pixel <= frag_wr_q;
			last <= frag_fin_q;
			red <= frag_wr_q ? (sat_q[0] ? 8'hFF : quo_q[0]) : 8'd0;
			green <= frag_wr_q ? (sat_q[1] ? 8'hFF : quo_q[1]) : 8'd0;
			blue <= frag_wr_q ? (sat_q[2] ? 8'hFF : quo_q[2]) : 8'd0;
		end
	end

	assign stat.empty = empty;
	assign stat.active = active_q;
	assign stat.frag_wr = frag_wr_q;
endmodule
`default_nettype wire

// File: tb/ter_checker.sv
// Checker that predicts the fragments of the triangle edge rasterizer and compares them.
`timescale 1ns / 100ps
module ter_checker (
	input wire logic clk,
	input wire logic arst_n,
	ter_in_if cmd,
	ter_out_if frag,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic pready,
	input wire logic [ter_pkg::AW-1:0] paddr,
	input wire logic [ter_pkg::DATA_W-1:0] pwdata,
	output int errors,
	output int pending
);
	import ter_pkg::*;

	typedef struct {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic wr;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic last;
	} fragment_t;

	fragment_t frag_queue[$];

	logic [23:0] color[3];
	logic [10:0] scr_w, scr_h;

	logic scanning;
	logic signed [COORD_BITS-1:0] col, row, left, right, bottom;
	logic signed [WW-1:0] weight[3], row_weight[3], area;
	logic signed [DW-1:0] dcol[3], drow[3];

	assign pending = frag_queue.size();

	function automatic longint edge_cross(longint ax, longint ay, longint bx, longint by,
		longint cx, longint cy);
		return (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
	endfunction

	// Top and left edges keep their pixels; every other edge loses the pixels on it.
	function automatic longint fill_bias(longint sx, longint sy, longint ex, longint ey);
		if ((ey == sy && ex > sx) || ey < sy)
			return 0;
		return -1;
	endfunction

	function automatic logic [7:0] blend(int shift);
		longint num, q;
		num = 0;
		for (int i = 0; i < 3; i++)
			num += longint'(weight[i]) * longint'((color[i] >> shift) & 24'hFF);
		q = num / longint'(area);
		return (q > 255) ? 8'd255 : q[7:0];
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	task automatic load_triangle();
		longint x[3], y[3], xmin, xmax, ymin, ymax;
		fragment_t f;
		x[0] = longint'(cmd.first_x); y[0] = longint'(cmd.first_y);
		x[1] = longint'(cmd.second_x); y[1] = longint'(cmd.second_y);
		x[2] = longint'(cmd.third_x); y[2] = longint'(cmd.third_y);
		xmin = x[0]; xmax = x[0]; ymin = y[0]; ymax = y[0];
		for (int i = 1; i < 3; i++) begin
			if (x[i] < xmin) xmin = x[i];
			if (x[i] > xmax) xmax = x[i];
			if (y[i] < ymin) ymin = y[i];
			if (y[i] > ymax) ymax = y[i];
		end
		for (int i = 0; i < 3; i++) begin
			dcol[i] = DW'(y[(i + 1) % 3] - y[(i + 2) % 3]);
			drow[i] = DW'(x[(i + 2) % 3] - x[(i + 1) % 3]);
			row_weight[i] = WW'(edge_cross(x[(i + 1) % 3], y[(i + 1) % 3], x[(i + 2) % 3],
				y[(i + 2) % 3], xmin, ymin) + fill_bias(x[(i + 1) % 3], y[(i + 1) % 3],
				x[(i + 2) % 3], y[(i + 2) % 3]));
			weight[i] = row_weight[i];
		end
		area = WW'(edge_cross(x[0], y[0], x[1], y[1], x[2], y[2]));
		left = COORD_BITS'(xmin); col = COORD_BITS'(xmin); row = COORD_BITS'(ymin);
		if (xmin == xmax || ymin == ymax) begin
			// A flat box still reports one closing fragment.
			scanning = 1'b0;
			right = COORD_BITS'(xmin); bottom = COORD_BITS'(ymin);
			f.x = COORD_BITS'(xmin); f.y = COORD_BITS'(ymin); f.wr = 1'b0;
			f.r = 8'd0; f.g = 8'd0; f.b = 8'd0; f.last = 1'b1;
			frag_queue.push_back(f);
		end else begin
			right = COORD_BITS'(xmax - 1); bottom = COORD_BITS'(ymax - 1);
			scanning = 1'b1;
		end
	endtask

	task automatic step_scan();
		fragment_t f;
		logic covered, visible;
		covered = weight[0] >= 0 && weight[1] >= 0 && weight[2] >= 0 && area > 0;
		visible = col >= 0 && col < $signed({2'b0, scr_w}) && row >= 0 &&
			row < $signed({2'b0, scr_h});
		f.x = col; f.y = row; f.wr = covered && visible;
		f.r = f.wr ? blend(16) : 8'd0;
		f.g = f.wr ? blend(8) : 8'd0;
		f.b = f.wr ? blend(0) : 8'd0;
		f.last = (col == right && row == bottom);
		frag_queue.push_back(f);
		if (f.last) begin
			scanning = 1'b0;
		end else if (col == right) begin
			col = left;
			row = row + COORD_BITS'(1);
			for (int i = 0; i < 3; i++) begin
				row_weight[i] = row_weight[i] + drow[i];
				weight[i] = row_weight[i];
			end
		end else begin
			col = col + COORD_BITS'(1);
			for (int i = 0; i < 3; i++)
				weight[i] = weight[i] + dcol[i];
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		fragment_t want;
		if (!arst_n) begin
			errors = 0;
			frag_queue.delete();
			color[0] = 24'hFF0000; color[1] = 24'h00FF00; color[2] = 24'h0000FF;
			scr_w = 11'd800; scr_h = 11'd600;
			scanning = 1'b0;
		end else begin
			if (frag.valid && frag.ready) begin
				if (frag_queue.size() == 0) begin
					report("unexpected fragment pixel_x", frag.pixel_x, 0);
				end else begin
					want = frag_queue.pop_front();
					if (frag.pixel_x !== want.x) report("pixel_x", frag.pixel_x, want.x);
					if (frag.pixel_y !== want.y) report("pixel_y", frag.pixel_y, want.y);
					if (frag.write_pixel !== want.wr)
						report("write_pixel", frag.write_pixel, want.wr);
					if (frag.red !== want.r) report("red", frag.red, want.r);
					if (frag.green !== want.g) report("green", frag.green, want.g);
					if (frag.blue !== want.b) report("blue", frag.blue, want.b);
					if (frag.last !== want.last) report("last", frag.last, want.last);
				end
			end
			if (cmd.valid && cmd.ready) begin
				if (cmd.kind == KIND_START)
					load_triangle();
				else if (scanning)
					step_scan();
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[AW-1:2])
					REG_V0_COLOR: color[0] = pwdata[23:0];
					REG_V1_COLOR: color[1] = pwdata[23:0];
					REG_V2_COLOR: color[2] = pwdata[23:0];
					REG_SCR_WIDTH: scr_w = pwdata[10:0];
					REG_SCR_HEIGHT: scr_h = pwdata[10:0];
					default: ;
				endcase
			end
		end
	end
endmodule

// File: tb/testbench.sv
// Top of the rasterizer testbench: stimulus, register phases, receiver stalls and verdict.
`timescale 1ns / 100ps
module testbench;
	import ter_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [AW-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;
	int errors, pending;
	int items_sent = 0;
	int burst_left = 0;
	int quiet_cycles = 0;
	int scr_w = 800, scr_h = 600;

	ter_in_if cmd_ch();
	ter_out_if frag_ch();

	// Inputs start at known values before the first clock edge.
	initial begin
		cmd_ch.valid = 1'b0;
		cmd_ch.kind = KIND_STEP;
		cmd_ch.first_x = '0; cmd_ch.first_y = '0;
		cmd_ch.second_x = '0; cmd_ch.second_y = '0;
		cmd_ch.third_x = '0; cmd_ch.third_y = '0;
		frag_ch.ready = 1'b0;
	end

	triangle_edge_rasterizer uut (
		.clk(clk), .arst_n(arst_n), .cmd(cmd_ch), .frag(frag_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	ter_checker u_checker (
		.clk(clk), .arst_n(arst_n), .cmd(cmd_ch), .frag(frag_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata), .errors(errors), .pending(pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The watchdog counts cycles in which no transfer happens on either channel. The
	// longest legal quiet stretch is the long receiver hold-off.
	always @(posedge clk) begin
		if ((cmd_ch.valid && cmd_ch.ready) || (frag_ch.valid && frag_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= 3000) begin
			$display("[triangle_edge_rasterizer] ERROR");
			$finish;
		end
	end

	// The receiver switches between stall patterns, and once, after a few hundred items,
	// holds off for a long stretch so that the output register and the input stall.
	initial begin
		int hold_left, pattern, pattern_left;
		bit held;
		hold_left = 0; pattern = 0; pattern_left = 0; held = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held && items_sent >= 300) begin
				held = 1;
				hold_left = 400;
			end
			if (pattern_left == 0) begin
				pattern = $urandom_range(0, 3);
				pattern_left = $urandom_range(16, 128);
			end
			pattern_left--;
			if (hold_left > 0) begin
				hold_left--;
				frag_ch.ready <= 1'b0;
			end else begin
				case (pattern)
					0: frag_ch.ready <= 1'b1;
					1: frag_ch.ready <= ($urandom_range(0, 1) == 1);
					2: frag_ch.ready <= ($urandom_range(0, 7) == 0);
					default: frag_ch.ready <= ($urandom_range(0, 5) != 0);
				endcase
			end
		end
	end

	// One transfer on the cmd channel. The sender works in bursts; between bursts valid
	// may drop for a random gap. Ready is sampled at the falling edge, where it already holds
	// the value that the next rising edge sees.
	task automatic send(logic kind, int x0, int y0, int x1, int y1, int x2, int y2);
		bit taken;
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				cmd_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		cmd_ch.valid <= 1'b1;
		cmd_ch.kind <= kind;
		cmd_ch.first_x <= COORD_BITS'(x0); cmd_ch.first_y <= COORD_BITS'(y0);
		cmd_ch.second_x <= COORD_BITS'(x1); cmd_ch.second_y <= COORD_BITS'(y1);
		cmd_ch.third_x <= COORD_BITS'(x2); cmd_ch.third_y <= COORD_BITS'(y2);
		do begin
			@(negedge clk);
			taken = cmd_ch.ready;
			@(posedge clk);
		end while (!taken);
		items_sent++;
	endtask

	task automatic step();
		send(KIND_STEP, $urandom_range(0, 4095), $urandom_range(0, 4095),
			$urandom_range(0, 4095), $urandom_range(0, 4095),
			$urandom_range(0, 4095), $urandom_range(0, 4095));
	endtask

	// A start followed by the steps of its whole box, or fewer to break the scan off.
	task automatic triangle(int x0, int y0, int x1, int y1, int x2, int y2, int steps);
		send(KIND_START, x0, y0, x1, y1, x2, y2);
		repeat (steps) step();
	endtask

	function automatic int box_steps(int x0, int y0, int x1, int y1, int x2, int y2);
		int w, h;
		w = (x0 > x1 ? (x0 > x2 ? x0 : x2) : (x1 > x2 ? x1 : x2)) -
			(x0 < x1 ? (x0 < x2 ? x0 : x2) : (x1 < x2 ? x1 : x2));
		h = (y0 > y1 ? (y0 > y2 ? y0 : y2) : (y1 > y2 ? y1 : y2)) -
			(y0 < y1 ? (y0 < y2 ? y0 : y2) : (y1 < y2 ? y1 : y2));
		return w * h;
	endfunction

	// Setup phase, access phase, then an idle phase before the next write.
	task automatic apb_write(logic [2:0] index, logic [DATA_W-1:0] value);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= AW'(index) << 2; pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// Registers change only once every fragment is home and a step or start that makes no
	// fragment has had time to finish its setup.
	task automatic set_registers(int c0, int c1, int c2, int w, int h);
		cmd_ch.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		apb_write(REG_V0_COLOR, c0);
		apb_write(REG_V1_COLOR, c1);
		apb_write(REG_V2_COLOR, c2);
		apb_write(REG_SCR_WIDTH, w);
		apb_write(REG_SCR_HEIGHT, h);
		scr_w = w; scr_h = h;
	endtask

	// A random small triangle, placed near a screen border or anywhere in the range.
	task automatic random_triangle();
		int bx, by, x[3], y[3], full;
		case ($urandom_range(0, 3))
			0: begin bx = $urandom_range(0, 8) - 4; by = $urandom_range(0, 8) - 4; end
			1: begin bx = scr_w - $urandom_range(0, 6); by = scr_h - $urandom_range(0, 6); end
			2: begin bx = $urandom_range(0, 40); by = $urandom_range(0, 40); end
			default: begin
				bx = $urandom_range(0, 4087) - 2048;
				by = $urandom_range(0, 4087) - 2048;
			end
		endcase
		for (int i = 0; i < 3; i++) begin
			x[i] = bx + $urandom_range(0, 6);
			y[i] = by + $urandom_range(0, 6);
		end
		full = box_steps(x[0], y[0], x[1], y[1], x[2], y[2]);
		if ($urandom_range(0, 9) == 0 && full > 0)
			full = $urandom_range(0, full - 1);
		triangle(x[0], y[0], x[1], y[1], x[2], y[2], full);
		if ($urandom_range(0, 7) == 0)
			step();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part with the reset register values.
		step();
		triangle(-2048, -2048, 2047, 2047, -2048, 2047, 3);
		triangle(2047, -2048, -2048, 2047, 2047, 2047, 2);
		triangle(5, 5, 9, 5, 2, 5, 0);
		triangle(7, 1, 7, 4, 7, 9, 0);
		triangle(0, 0, 3, 3, 3, 0, 9);
		triangle(0, 0, 3, 0, 3, 3, 9);
		step();

		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: set_registers(24'h000000, 24'hFFFFFF, 24'h000000, 1, 2047);
				1: set_registers(24'hFFFFFF, 24'h000000, 24'hFFFFFF, 2047, 1);
				2: set_registers(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 2047, 2047);
				3: set_registers($urandom_range(0, 24'hFFFFFF), $urandom_range(0, 24'hFFFFFF),
					$urandom_range(0, 24'hFFFFFF), $urandom_range(1, 40),
					$urandom_range(1, 40));
				default: set_registers(24'hFF0000, 24'h00FF00, 24'h0000FF, 800, 600);
			endcase
			while (items_sent < 25 + (phase + 1) * 220)
				random_triangle();
		end

		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("[triangle_edge_rasterizer] OK");
		else
			$display("[triangle_edge_rasterizer] ERROR");
		$finish;
	end
endmodule

// File: filelist.f
sv/ter_pkg.sv
sv/ter_if.sv
sv/ter_cfg.sv
sv/ter_ctrl.sv
sv/ter_dp.sv
sv/triangle_edge_rasterizer.sv
tb/ter_checker.sv
tb/testbench.sv
